// File: rtl/lsw_pkg.sv
// Shared types, constants and tables of the layered sine-wave column shader.
package lsw_pkg;

  localparam int COLUMN_W = 7;
  localparam int ROW_W = 6;
  localparam int SHADE_W = 8;
  localparam int PHASE_W = 8;
  localparam int LAYER_MAX = 8;
  localparam int LAYER_W = 3;
  localparam int DEF_LAYER_COUNT = 8;

  localparam logic [COLUMN_W-1:0] COLUMN_LAST = 7'd127;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                rebuild;
  } lsw_cmd_t;

  localparam logic [PHASE_W-1:0] PHASE_INIT [LAYER_MAX] = '{
    8'd0, 8'd32, 8'd64, 8'd96, 8'd100, 8'd120, 8'd140, 8'd160
  };

  localparam logic [PHASE_W-1:0] PHASE_STEP [LAYER_MAX] = '{
    8'd251, 8'd253, 8'd254, 8'd255, 8'd4, 8'd2, 8'd7, 8'd8
  };

  localparam logic [7:0] SINE_ROM [256] = '{
    8'd64, 8'd65, 8'd67, 8'd68, 8'd70, 8'd72, 8'd73, 8'd75,
    8'd76, 8'd78, 8'd79, 8'd81, 8'd82, 8'd84, 8'd85, 8'd87,
    8'd88, 8'd90, 8'd91, 8'd92, 8'd94, 8'd95, 8'd97, 8'd98,
    8'd99, 8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108,
    8'd109, 8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116,
    8'd117, 8'd118, 8'd118, 8'd119, 8'd120, 8'd121, 8'd121, 8'd122,
    8'd123, 8'd123, 8'd124, 8'd124, 8'd125, 8'd125, 8'd126, 8'd126,
    8'd126, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
    8'd128, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
    8'd126, 8'd126, 8'd126, 8'd125, 8'd125, 8'd124, 8'd124, 8'd123,
    8'd123, 8'd122, 8'd121, 8'd121, 8'd120, 8'd119, 8'd118, 8'd118,
    8'd117, 8'd116, 8'd115, 8'd114, 8'd113, 8'd112, 8'd111, 8'd110,
    8'd109, 8'd108, 8'd107, 8'd105, 8'd104, 8'd103, 8'd102, 8'd100,
    8'd99, 8'd98, 8'd97, 8'd95, 8'd94, 8'd92, 8'd91, 8'd90,
    8'd88, 8'd87, 8'd85, 8'd84, 8'd82, 8'd81, 8'd79, 8'd78,
    8'd76, 8'd75, 8'd73, 8'd72, 8'd70, 8'd68, 8'd67, 8'd65,
    8'd64, 8'd62, 8'd61, 8'd59, 8'd58, 8'd56, 8'd54, 8'd53,
    8'd51, 8'd50, 8'd48, 8'd47, 8'd45, 8'd44, 8'd42, 8'd41,
    8'd39, 8'd38, 8'd36, 8'd35, 8'd34, 8'd32, 8'd31, 8'd30,
    8'd28, 8'd27, 8'd26, 8'd25, 8'd23, 8'd22, 8'd21, 8'd20,
    8'd19, 8'd18, 8'd17, 8'd15, 8'd14, 8'd13, 8'd13, 8'd12,
    8'd11, 8'd10, 8'd9, 8'd8, 8'd8, 8'd7, 8'd6, 8'd5,
    8'd5, 8'd4, 8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2,
    8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1,
    8'd1, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd8, 8'd9, 8'd10,
    8'd11, 8'd12, 8'd13, 8'd13, 8'd14, 8'd15, 8'd17, 8'd18,
    8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd25, 8'd26, 8'd27,
    8'd28, 8'd30, 8'd31, 8'd32, 8'd34, 8'd35, 8'd36, 8'd38,
    8'd39, 8'd41, 8'd42, 8'd44, 8'd45, 8'd47, 8'd48, 8'd50,
    8'd51, 8'd53, 8'd54, 8'd56, 8'd58, 8'd59, 8'd61, 8'd62
  };

endpackage

// File: rtl/lsw_front.sv
// Input register that accepts pixel words and tags row-zero words as column rebuilds.
module lsw_front import lsw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COLUMN_W-1:0] column,
  input  logic [ROW_W-1:0]    row,
  output logic                push,
  output lsw_cmd_t            push_cmd,
  input  logic                q_full
);

  logic     held;
  logic     held_next;
  lsw_cmd_t cmd;

  assign in_stall = held && q_full;
  assign push = held && !q_full;
  assign push_cmd = cmd;

  always_comb begin
    held_next = held;
    if (in_valid && !in_stall) begin
      held_next = 1'b1;
    end else if (push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd.column <= column;
      cmd.row <= row;
      cmd.rebuild <= (row == '0);
    end
  end

endmodule

// File: rtl/lsw_fifo.sv
// Two-entry command queue between the front and back parts of the shader.
module lsw_fifo import lsw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lsw_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output lsw_cmd_t q_cmd
);

  lsw_cmd_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/lsw_back.sv
// Layer sequencer that rebuilds the column segments and answers shade reads.
module lsw_back import lsw_pkg::*; #(
  parameter int LAYER_COUNT = DEF_LAYER_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lsw_cmd_t           q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SHADE_W-1:0] shade
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;
  localparam logic [LAYER_W-1:0] LAST_LAYER = LAYER_W'(LAYER_COUNT - 1);

  logic [1:0]          state;
  logic [LAYER_W-1:0]  layer;
  logic [ROW_W-1:0]    top;
  logic [COLUMN_W-1:0] cmd_column;
  logic [ROW_W-1:0]    cmd_row;
  logic [PHASE_W-1:0]  phases [LAYER_MAX];
  logic                seg_en [LAYER_MAX];
  logic [ROW_W-1:0]    seg_lo [LAYER_MAX];
  logic [ROW_W-1:0]    seg_hi [LAYER_MAX];

  logic               out_free;
  logic [7:0]         sine_idx;
  logic [ROW_W-1:0]   height;
  logic [ROW_W-1:0]   read_row;
  logic [SHADE_W-1:0] read_shade;
  logic [ROW_W-1:0]   diff [LAYER_MAX];
  logic [SHADE_W-1:0] seg_val [LAYER_MAX];
  logic               hit [LAYER_MAX];

  assign out_free = !out_valid || !out_stall;
  assign pop = (state == ST_IDLE) && q_valid && out_free;
  assign sine_idx = phases[layer] + {1'b0, cmd_column};
  assign height = ROW_W'(SINE_ROM[sine_idx] >> 2) + ROW_W'({layer, 2'b00});
  assign read_row = (state == ST_IDLE) ? q_cmd.row : cmd_row;

  // Layer segments never overlap, so at most one of them covers a row.
  always_comb begin
    read_shade = '0;
    for (int i = 0; i < LAYER_MAX; i++) begin
      hit[i] = seg_en[i] && (read_row >= seg_lo[i]) && (read_row < seg_hi[i]);
      diff[i] = read_row - seg_lo[i];
      seg_val[i] = {2'b00, LAYER_W'(i), 3'b000} - {1'b0, diff[i], 1'b0};
      if (hit[i]) begin
        read_shade = read_shade | seg_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < LAYER_MAX; i++) begin
        seg_en[i] <= 1'b0;
        phases[i] <= PHASE_INIT[i];
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_cmd.rebuild) begin
              state <= ST_BUILD;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_BUILD: begin
          seg_en[layer] <= (height > top);
          if (cmd_column == COLUMN_LAST) begin
            phases[layer] <= phases[layer] + PHASE_STEP[layer];
          end
          if (layer == LAST_LAYER) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_column <= q_cmd.column;
      cmd_row <= q_cmd.row;
      layer <= '0;
      top <= '0;
    end
    if (state == ST_BUILD) begin
      seg_lo[layer] <= top;
      seg_hi[layer] <= height;
      if (height > top) begin
        top <= height;
      end
      layer <= layer + LAYER_W'(1);
    end
    if ((pop && !q_cmd.rebuild) || (state == ST_RESP && out_free)) begin
      shade <= read_shade;
    end
  end

endmodule

// File: rtl/layered_sine_wave_column_shader_core.sv
// Top level of the layered sine-wave column shader.
// Pixel words (column, row) arrive on the input channel in raster order under
// in_valid and in_stall, and each one yields exactly one shade word on the
// output channel under out_valid and out_stall, in the same order.
// A word with row 0 rebuilds the column: the sequencer walks the layers one per
// cycle, reading the sine table and recording where each layer covers rows,
// and then answers the shade at row 0. Other rows are read from those layer
// segments directly.
// An ordinary row passes through the input register, the queue and the shade
// output register; row 0 also occupies the layer sequencer for its build and response states.
// Ordinary rows stream at one word per cycle while the output is not stalled.
// A two-entry queue between the input register and the sequencer lets the
// input side keep taking words while the sequencer is busy or the output is
// stalled; in_stall rises only once the queue and input register are full.
// A stalled output word holds its value until it is taken.
// Reset empties the queue, drops any pending word, clears the column to all
// zero shades and restores the initial layer phases.
module layered_sine_wave_column_shader_core import lsw_pkg::*; #(
  parameter int LAYER_COUNT = DEF_LAYER_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COLUMN_W-1:0] column,
  input  logic [ROW_W-1:0]    row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SHADE_W-1:0]  shade
);

  logic     push;
  lsw_cmd_t push_cmd;
  logic     q_full;
  logic     q_valid;
  lsw_cmd_t q_cmd;
  logic     pop;

  lsw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .column   (column),
    .row      (row),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  lsw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  lsw_back #(
    .LAYER_COUNT (LAYER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .shade     (shade)
  );

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("Sequencer took a word from an empty queue.");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shade))
    else $error("Stalled shade word changed or vanished.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !push)
    else $error("Front pushed into a full queue.");

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid && !in_stall)
    else $error("Channels active right after reset.");

endmodule

// File: tb/lsw_shade_checker.sv
// Shade checker: predicts every shade word from the accepted pixel words and compares it.
module lsw_shade_checker import lsw_pkg::*; #(
  parameter int LAYER_COUNT = DEF_LAYER_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [COLUMN_W-1:0] column,
  input  logic [ROW_W-1:0]    row,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [SHADE_W-1:0]  shade,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [SHADE_W-1:0]  shade;
  } pixel_shade_t;

  localparam int ROWS = 1 << ROW_W;

  logic [SHADE_W-1:0] column_shades [ROWS];
  logic [PHASE_W-1:0] layer_phases [LAYER_MAX];
  pixel_shade_t       pending_shades [$];
  int                 fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [SHADE_W-1:0] predict_shade(input logic [COLUMN_W-1:0] c,
                                                       input logic [ROW_W-1:0] r);
    int                 ceiling;
    int                 height;
    logic [7:0]         sine_index;
    logic [SHADE_W-1:0] fill;
    if (r == '0) begin
      ceiling = 0;
      foreach (column_shades[i]) column_shades[i] = '0;
      for (int layer = 0; layer < LAYER_COUNT; layer++) begin
        sine_index = layer_phases[layer] + c;
        height = int'(SINE_ROM[sine_index] >> 2) + 4 * layer;
        if (height > ceiling) begin
          fill = SHADE_W'(layer * 8);
          for (int y = ceiling; y < height && y < ROWS; y++) begin
            column_shades[y] = fill;
            fill = fill - 8'd2;
          end
          ceiling = height;
        end
        if (c == COLUMN_LAST) begin
          layer_phases[layer] = layer_phases[layer] + PHASE_STEP[layer];
        end
      end
    end
    return column_shades[r];
  endfunction

  always @(posedge clk) begin
    pixel_shade_t head;
    pixel_shade_t fresh;
    if (rst) begin
      pending_shades.delete();
      foreach (column_shades[i]) column_shades[i] = '0;
      foreach (layer_phases[i]) layer_phases[i] = PHASE_INIT[i];
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_shades.size() == 0) begin
          report_mismatch($sformatf("shade word %0d arrived with nothing expected", shade));
        end else begin
          head = pending_shades.pop_front();
          if (shade !== head.shade) begin
            report_mismatch($sformatf("column %0d row %0d: shade %0d, expected %0d",
                                      head.column, head.row, shade, head.shade));
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.column = column;
        fresh.row = row;
        fresh.shade = predict_shade(column, row);
        pending_shades.push_back(fresh);
      end
    end
    outstanding <= pending_shades.size();
    mismatches <= fail_count;
  end

endmodule

// File: tb/layered_sine_wave_column_shader_core_tb.sv
// Testbench top: drives pixel words and output stalls into the shader and gives the verdict.
module layered_sine_wave_column_shader_core_tb import lsw_pkg::*;;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1900;
  localparam int DRAIN_CYCLES = 16;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [COLUMN_W-1:0] column = '0;
  logic [ROW_W-1:0]    row = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SHADE_W-1:0]  shade;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int words_sent = 0;
  int idle_mode = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  layered_sine_wave_column_shader_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .row       (row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .shade     (shade)
  );

  lsw_shade_checker #(.LAYER_COUNT(DEF_LAYER_COUNT)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .column      (column),
    .row         (row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .shade       (shade),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 255) == 0) begin
        stall_mode <= $urandom_range(0, 2);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (stall_mode != 0 &&
                   $urandom_range(0, 99) < (stall_mode == 1 ? 10 : 40)) begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int pct;
    if ($urandom_range(0, 63) == 0) begin
      idle_mode = $urandom_range(0, 1);
    end
    if (idle_mode == 0) begin
      return 0;
    end
    pct = $urandom_range(0, 99);
    if (pct < 70) begin
      return 0;
    end
    if (pct < 97) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(input logic [COLUMN_W-1:0] c, input logic [ROW_W-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column <= c;
    row <= r;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  initial begin
    logic [COLUMN_W-1:0] raster_column;
    logic [COLUMN_W-1:0] c;
    int                  y;
    raster_column = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Rows read before any rebuild see the cleared store.
    send_pixel(7'd0, 6'd1);
    send_pixel(7'd0, 6'd63);
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd0, 6'd1);
    send_pixel(7'd0, 6'd30);
    send_pixel(7'd0, 6'd63);
    // The last column advances the phases on every row-0 word.
    send_pixel(COLUMN_LAST, 6'd0);
    send_pixel(COLUMN_LAST, 6'd0);
    send_pixel(COLUMN_LAST, 6'd63);
    send_pixel(COLUMN_LAST, 6'd5);
    send_pixel(7'd64, 6'd0);
    send_pixel(7'd64, 6'd40);
    send_pixel(7'd64, 6'd59);
    // A read for another column returns what the last rebuild left.
    send_pixel(7'd5, 6'd17);
    send_pixel(7'd100, 6'd0);
    send_pixel(7'd100, 6'd0);
    send_pixel(7'd1, 6'd0);
    send_pixel(7'd126, 6'd0);
    send_pixel(COLUMN_LAST, 6'd0);
    send_pixel(7'd85, 6'd42);
    send_pixel(7'd42, 6'd21);
    send_pixel(7'd85, 6'd0);
    send_pixel(7'd42, 6'd0);
    send_pixel(7'd42, 6'd62);

    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(COLUMN_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            c = COLUMN_LAST;
          end
          1: begin
            c = COLUMN_W'($urandom_range(0, 127));
          end
          default: begin
            c = raster_column;
          end
        endcase
        raster_column = c + 7'd1;
        send_pixel(c, 6'd0);
        if ($urandom_range(0, 11) == 0) begin
          for (y = 1; y < 64; y++) begin
            send_pixel(c, ROW_W'(y));
          end
        end else begin
          y = $urandom_range(1, 6);
          while (y < 64) begin
            send_pixel(c, ROW_W'(y));
            y = y + $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lsw_pkg.sv
rtl/lsw_front.sv
rtl/lsw_fifo.sv
rtl/lsw_back.sv
rtl/layered_sine_wave_column_shader_core.sv
tb/lsw_shade_checker.sv
tb/layered_sine_wave_column_shader_core_tb.sv
